>>> hw/rtl/nalsplit_pkg.sv
`default_nettype none

package nalsplit_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
  // room for the word in the input register plus one more accepted word
  localparam int READY_LEVEL = QUEUE_DEPTH - 2 * MAX_RESULTS;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE = 8'h01;
  localparam logic [7:0] KIND_MASK = 8'h1F;
  localparam logic [4:0] KIND_SLICE = 5'd1;
  localparam logic [4:0] KIND_IDR = 5'd5;
  localparam logic [2:0] COUNT_MAX = 3'd5;
  localparam logic [2:0] HDR_POS_SHORT = 3'd3;
  localparam logic [2:0] HDR_POS_LONG = 3'd4;
  localparam logic [2:0] MIN_UNIT = 3'd3;
  localparam logic [2:0] WIN_DEPTH = 3'd4;
  localparam logic [2:0] WIN_KEEP = 3'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_first;
    logic       unit_last;
    logic [4:0] unit_kind;
    logic       frame_last;
  } res_t;

  typedef struct packed {
    logic [2:0]                   count;
    res_t [MAX_RESULTS-1:0]       items;
  } push_t;

endpackage

`default_nettype wire

>>> hw/rtl/nalsplit_if.sv
`default_nettype none

interface nalsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source(output valid, output data_byte, output stream_end, input ready);
  modport sink(input valid, input data_byte, input stream_end, output ready);
endinterface

interface nalsplit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       unit_first;
  logic       unit_last;
  logic [4:0] unit_kind;
  logic       frame_last;

  modport source(output valid, output out_byte, output unit_first, output unit_last,
                 output unit_kind, output frame_last, input ready);
  modport sink(input valid, input out_byte, input unit_first, input unit_last,
               input unit_kind, input frame_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/annexb_nal_access_unit_splitter.sv
`default_nettype none

// Annex B start-code splitter. Takes one stream byte per cycle and returns the
// NAL unit bytes (start code included) with first/last marks, the NAL type on
// the last byte and an access-unit end mark after type 1 or 5 units or at a
// stream end. Bytes before the first start code are dropped. A byte marked
// stream_end flushes the four-byte window, so that byte can yield up to five
// result words; all other bytes yield at most one. Each byte passes an input
// register, then the window compare, whose result words are registered on
// their way into a 16-word result queue. Input is taken every cycle while the
// queue holds six words or fewer, which sustains one byte per cycle when the
// output side takes a word every cycle.
module annexb_nal_access_unit_splitter (
  input wire logic clk,
  input wire logic rst,
  nalsplit_in_if.sink    byte_in,
  nalsplit_out_if.source unit_out
);
  import nalsplit_pkg::*;

  logic               accept;
  logic               pop;
  push_t              push;
  res_t               head;
  logic               head_valid;
  logic [LEVEL_W-1:0] level;

  assign byte_in.ready = level <= LEVEL_W'(READY_LEVEL);
  assign accept        = byte_in.valid && byte_in.ready;
  assign pop           = unit_out.valid && unit_out.ready;

  nalsplit_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (byte_in.data_byte),
    .stream_end (byte_in.stream_end),
    .push       (push)
  );

  nalsplit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  assign unit_out.valid      = head_valid;
  assign unit_out.out_byte   = head.out_byte;
  assign unit_out.unit_first = head.unit_first;
  assign unit_out.unit_last  = head.unit_last;
  assign unit_out.unit_kind  = head.unit_kind;
  assign unit_out.frame_last = head.frame_last;

endmodule

`default_nettype wire

>>> hw/rtl/nalsplit_parser.sv
`default_nettype none

module nalsplit_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          data_byte,
  input  wire logic                stream_end,
  output nalsplit_pkg::push_t      push
);
  import nalsplit_pkg::*;

  typedef struct packed {
    logic [2:0] cnt;
    logic [4:0] kind;
  } unit_pos_t;

  function automatic unit_pos_t take_byte(unit_pos_t s, logic lng, logic [7:0] b);
    unit_pos_t r;
    r = s;
    if ((!lng && s.cnt == HDR_POS_SHORT) || (lng && s.cnt == HDR_POS_LONG)) begin
      r.kind = b[4:0] & KIND_MASK[4:0];
    end
    if (s.cnt < COUNT_MAX) begin
      r.cnt = s.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic res_t make_res(logic [7:0] b, logic first, logic last,
                                    logic [4:0] kind, logic at_end);
    res_t r;
    r.out_byte   = b;
    r.unit_first = first;
    r.unit_last  = last;
    r.unit_kind  = last ? kind : 5'd0;
    r.frame_last = last && (at_end || kind == KIND_SLICE || kind == KIND_IDR);
    return r;
  endfunction

  // input register
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_end;

  // parser state
  logic [7:0] win [4];
  logic [2:0] fill;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       in_unit;
  logic [2:0] unit_count;
  logic       long_start;
  logic [4:0] current_kind;

  logic [7:0] win_next [4];
  logic [2:0] fill_next;
  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic       in_unit_next;
  logic [2:0] unit_count_next;
  logic       long_start_next;
  logic [4:0] current_kind_next;
  push_t      push_next;

  always_comb begin
    logic [7:0] w [4];
    logic [2:0] f;
    logic       sc;
    logic       last_h;
    logic       iu;
    logic       hv;
    logic [7:0] hb;
    logic       lng;
    unit_pos_t  pos;
    logic [2:0] n;

    w   = win;
    f   = (fill > WIN_KEEP) ? WIN_KEEP : fill;
    sc  = 1'b0;
    last_h = 1'b0;
    iu  = in_unit;
    hv  = held_valid;
    hb  = held_byte;
    lng = long_start;
    pos.cnt  = unit_count;
    pos.kind = current_kind;
    n   = 3'd0;
    push_next.items = '0;

    if (ir_valid) begin
      w[f[1:0]] = ir_byte;
      f = f + 3'd1;

      if (f == WIN_DEPTH) begin
        sc = w[0] == BYTE_ZERO && w[1] == BYTE_ZERO &&
             (w[2] == BYTE_ONE || (w[2] == BYTE_ZERO && w[3] == BYTE_ONE));
        if (hv) begin
          last_h = pos.cnt >= MIN_UNIT && sc;
          push_next.items[n] = make_res(hb, pos.cnt == 3'd1, last_h, pos.kind, 1'b0);
          n  = n + 3'd1;
          hv = 1'b0;
          if (last_h) begin
            iu = 1'b0;
          end
        end
        if (!iu && sc) begin
          iu       = 1'b1;
          pos.cnt  = 3'd0;
          pos.kind = 5'd0;
          lng      = w[2] == BYTE_ZERO;
        end
        if (iu) begin
          hb  = w[0];
          pos = take_byte(pos, lng, w[0]);
          hv  = 1'b1;
        end
        w[0] = w[1];
        w[1] = w[2];
        w[2] = w[3];
        w[3] = BYTE_ZERO;
        f    = WIN_KEEP;
      end

      if (ir_end) begin
        if (iu) begin
          if (hv) begin
            push_next.items[n] = make_res(hb, pos.cnt == 3'd1, f == 3'd0, pos.kind, 1'b1);
            n = n + 3'd1;
          end
          for (int i = 0; i < 3; i++) begin
            if (3'(i) < f) begin
              pos = take_byte(pos, lng, w[i]);
              push_next.items[n] = make_res(w[i], pos.cnt == 3'd1, f == 3'(i + 1),
                                            pos.kind, 1'b1);
              n = n + 3'd1;
            end
          end
        end
        f        = 3'd0;
        hv       = 1'b0;
        hb       = BYTE_ZERO;
        iu       = 1'b0;
        lng      = 1'b0;
        pos.cnt  = 3'd0;
        pos.kind = 5'd0;
        for (int i = 0; i < 4; i++) begin
          w[i] = BYTE_ZERO;
        end
      end
    end

    win_next          = w;
    fill_next         = f;
    held_byte_next    = hb;
    held_valid_next   = hv;
    in_unit_next      = iu;
    unit_count_next   = pos.cnt;
    long_start_next   = lng;
    current_kind_next = pos.kind;
    push_next.count   = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid     <= 1'b0;
      fill         <= 3'd0;
      held_valid   <= 1'b0;
      in_unit      <= 1'b0;
      unit_count   <= 3'd0;
      long_start   <= 1'b0;
      current_kind <= 5'd0;
      push.count   <= 3'd0;
    end else begin
      ir_valid     <= accept;
      fill         <= fill_next;
      held_valid   <= held_valid_next;
      in_unit      <= in_unit_next;
      unit_count   <= unit_count_next;
      long_start   <= long_start_next;
      current_kind <= current_kind_next;
      push.count   <= push_next.count;
    end
    if (accept) begin
      ir_byte <= data_byte;
      ir_end  <= stream_end;
    end
    win        <= win_next;
    held_byte  <= held_byte_next;
    push.items <= push_next.items;
  end

  a_held_in_unit: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> in_unit)
    else $error("held byte outside a unit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (ir_valid && ir_end) |=> (fill == 3'd0 && !in_unit && !held_valid))
    else $error("state not cleared after stream end");

  a_push_bound: assert property (@(posedge clk) disable iff (rst)
    push_next.count <= 3'(MAX_RESULTS) && fill <= WIN_KEEP)
    else $error("parser emitted too many words or window overfull");

endmodule

`default_nettype wire

>>> hw/rtl/nalsplit_queue.sv
`default_nettype none

module nalsplit_queue (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire nalsplit_pkg::push_t                  push,
  input  wire logic                                 pop,
  output nalsplit_pkg::res_t                        head,
  output logic                                      head_valid,
  output logic [nalsplit_pkg::LEVEL_W-1:0]          level
);
  import nalsplit_pkg::*;

  res_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (3'(i) < push.count) begin
        mem[wr_ptr + PTR_W'(i)] <= push.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level + LEVEL_W'(push.count) - LEVEL_W'(pop);
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = level != '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (LEVEL_W + 1)'(level) + (LEVEL_W + 1)'(push.count) <= (LEVEL_W + 1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty result queue");

endmodule

`default_nettype wire

>>> sim/annexb_nal_access_unit_splitter_tb.sv
`timescale 1ns / 1ps

module annexb_nal_access_unit_splitter_tb;
  import nalsplit_pkg::*;

  localparam int RAND_ITEMS = 190;
  localparam int STALL_AT = 70;
  localparam int STALL_LEN = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       drain;
  } feed_t;

  logic clk;
  logic rst;

  nalsplit_in_if  byte_in();
  nalsplit_out_if unit_out();

  annexb_nal_access_unit_splitter uut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .unit_out(unit_out)
  );

  feed_t feed_q[$];
  res_t  nal_words_due[$];

  int n_total = 0;
  int n_in = 0;
  int n_out = 0;
  int n_units = 0;
  int n_frames = 0;
  int n_ends = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // splitter state as seen by the predictor
  logic [7:0] win [4];
  logic [2:0] win_fill;
  logic [7:0] held;
  logic       held_ok;
  logic       in_nal;
  logic [2:0] nal_len;
  logic       long_sc;
  logic [4:0] cur_type;

  function automatic void clear_splitter();
    for (int i = 0; i < 4; i++) win[i] = BYTE_ZERO;
    win_fill = '0;
    held = BYTE_ZERO;
    held_ok = 1'b0;
    in_nal = 1'b0;
    nal_len = '0;
    long_sc = 1'b0;
    cur_type = '0;
  endfunction

  function automatic logic start_in_window();
    return win_fill == WIN_DEPTH && win[0] == BYTE_ZERO && win[1] == BYTE_ZERO &&
           (win[2] == BYTE_ONE || (win[2] == BYTE_ZERO && win[3] == BYTE_ONE));
  endfunction

  function automatic logic [7:0] shift_window();
    logic [7:0] b;
    b = win[0];
    win[0] = win[1];
    win[1] = win[2];
    win[2] = win[3];
    win[3] = BYTE_ZERO;
    if (win_fill != 0) win_fill = win_fill - 3'd1;
    return b;
  endfunction

  function automatic void count_byte(input logic [7:0] b);
    logic [7:0] masked;
    masked = b & KIND_MASK;
    if ((!long_sc && nal_len == HDR_POS_SHORT) || (long_sc && nal_len == HDR_POS_LONG))
      cur_type = masked[4:0];
    if (nal_len < COUNT_MAX) nal_len = nal_len + 3'd1;
  endfunction

  function automatic void due_word(input logic [7:0] b, input logic first, input logic last,
                                   input logic at_end);
    res_t w;
    w.out_byte = b;
    w.unit_first = first;
    w.unit_last = last;
    w.unit_kind = last ? cur_type : 5'd0;
    w.frame_last = last && (at_end || cur_type == KIND_SLICE || cur_type == KIND_IDR);
    nal_words_due.push_back(w);
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic at_end);
    logic       sc;
    logic       closes;
    logic [7:0] c;
    if (win_fill > WIN_KEEP) win_fill = WIN_KEEP;
    win[win_fill[1:0]] = b;
    win_fill = win_fill + 3'd1;

    if (win_fill == WIN_DEPTH) begin
      sc = start_in_window();
      if (held_ok) begin
        closes = nal_len >= MIN_UNIT && sc;
        due_word(held, nal_len == 3'd1, closes, 1'b0);
        held_ok = 1'b0;
        if (closes) in_nal = 1'b0;
      end
      if (!in_nal) begin
        if (sc) begin
          in_nal = 1'b1;
          nal_len = '0;
          cur_type = '0;
          long_sc = win[2] == BYTE_ZERO;
        end else begin
          c = shift_window();
        end
      end
      if (in_nal) begin
        held = shift_window();
        count_byte(held);
        held_ok = 1'b1;
      end
    end

    if (at_end) begin
      if (in_nal) begin
        if (held_ok) due_word(held, nal_len == 3'd1, win_fill == 0, 1'b1);
        while (win_fill != 0) begin
          c = shift_window();
          count_byte(c);
          due_word(c, nal_len == 3'd1, win_fill == 0, 1'b1);
        end
      end
      clear_splitter();
    end
  endfunction

  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (n_total == 0) ? 0 : n_in * 3 / n_total;
    if (phase == 0) return sender ? 26 : 45;
    if (phase == 1) return sender ? 45 : 26;
    return 0;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 3) == 0) return BYTE_ZERO;
    if ($urandom_range(0, 7) == 0) return BYTE_ONE;
    return 8'($urandom);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last, input logic drain);
    feed_t f;
    f.b = b;
    f.last = last;
    f.drain = drain;
    feed_q.push_back(f);
  endtask

  task automatic add_stream(input bit drain_first);
    logic [7:0] s[$];
    logic [7:0] hdr;
    bit         end_it;
    int         units;
    repeat ($urandom_range(0, 3)) s.push_back(noise_byte());
    units = $urandom_range(1, 5);
    repeat (units) begin
      if ($urandom_range(0, 1) == 1) s.push_back(BYTE_ZERO);
      s.push_back(BYTE_ZERO);
      s.push_back(BYTE_ZERO);
      s.push_back(BYTE_ONE);
      // a few units are cut off before their header byte
      if ($urandom_range(0, 9) != 0) begin
        hdr = 8'($urandom);
        case ($urandom_range(0, 3))
          0: hdr[4:0] = KIND_SLICE;
          1: hdr[4:0] = KIND_IDR;
          default: ;
        endcase
        s.push_back(hdr);
        repeat ($urandom_range(0, 7)) s.push_back(noise_byte());
      end
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) s.push_back(BYTE_ZERO);
    end_it = $urandom_range(0, 5) != 0;
    for (int k = 0; k < s.size(); k++)
      add_byte(s[k], end_it && k == s.size() - 1, drain_first && k == 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : drive
    feed_t nxt;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        split_byte(byte_in.data_byte, byte_in.stream_end);
        if (byte_in.stream_end) n_ends++;
        n_in++;
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (feed_q.size() != 0 && !(feed_q[0].drain && nal_words_due.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = feed_q.pop_front();
          byte_in.valid <= 1'b1;
          byte_in.data_byte <= nxt.b;
          byte_in.stream_end <= nxt.last;
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      unit_out.ready <= 1'b0;
    end else if (stall_left != 0) begin
      unit_out.ready <= 1'b0;
      stall_left--;
    end else if (!stall_done && n_in >= STALL_AT) begin
      // long hold-off so the result queue fills and input backs up
      stall_done = 1'b1;
      stall_left = STALL_LEN;
      unit_out.ready <= 1'b0;
    end else begin
      unit_out.ready <= $urandom_range(0, 99) >= idle_pct(1'b0);
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst) begin
      if ((byte_in.valid && byte_in.ready) || (unit_out.valid && unit_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (unit_out.valid && unit_out.ready) begin
        n_out++;
        if (nal_words_due.size() == 0) begin
          $error("unexpected word: out_byte %0h", unit_out.out_byte);
          errors++;
        end else begin
          want = nal_words_due.pop_front();
          check_field("out_byte", want.out_byte, unit_out.out_byte);
          check_field("unit_first", want.unit_first, unit_out.unit_first);
          check_field("unit_last", want.unit_last, unit_out.unit_last);
          check_field("unit_kind", want.unit_kind, unit_out.unit_kind);
          check_field("frame_last", want.frame_last, unit_out.frame_last);
          if (want.unit_last) n_units++;
          if (want.frame_last) n_frames++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("annexb_nal_access_unit_splitter_tb: done, errors");
    $finish;
  end

  initial begin : main
    logic [143:0] seq_a;
    int           rand_base;
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.data_byte = 8'h00;
    byte_in.stream_end = 1'b0;
    unit_out.ready = 1'b0;
    clear_splitter();

    // leading junk, long start with masked type 5, short unit, flush on look-alike start
    seq_a = 144'hFF_00_00_00_01_E5_AA_00_00_01_00_00_01_41_80_00_00_01;
    for (int i = 17; i >= 0; i--) add_byte(seq_a[i*8 +: 8], i == 0, 1'b0);
    // end while still searching
    add_byte(8'h12, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    // end on the very first byte of a stream
    add_byte(8'h00, 1'b1, 1'b0);

    rand_base = feed_q.size();
    add_stream(1'b1);
    while (feed_q.size() - rand_base < RAND_ITEMS) add_stream(1'b0);
    n_total = feed_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || byte_in.valid) @(posedge clk);
    while (nal_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes (%0d stream ends) -> %0d words, %0d units, %0d frame ends",
             n_in, n_ends, n_out, n_units, n_frames);
    $display("with random idling on both sides, one long output hold-off and one full drain");
    if (errors == 0)
      $display("annexb_nal_access_unit_splitter_tb: done, clean");
    else
      $display("annexb_nal_access_unit_splitter_tb: done, errors");
    $finish;
  end

endmodule
